// File: design/prmt_pkg.sv
package prmt_pkg;

    // sizing
    localparam int DEF_ENTRIES = 128;
    localparam int IN_DATA_W   = 176;
    localparam int IN_USER_W   = 4;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_W       = 16;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd2500;
    localparam logic [7:0]       DEPTH_MAX     = 8'd255;

    // operation codes
    localparam logic [2:0] OP_RECORD = 3'd0;
    localparam logic [2:0] OP_REPLY  = 3'd1;
    localparam logic [2:0] OP_IMPACT = 3'd2;
    localparam logic [2:0] OP_BEGIN  = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // impact status codes
    localparam logic [1:0] STS_UNCHANGED = 2'd0;
    localparam logic [1:0] STS_WAIT      = 2'd1;
    localparam logic [1:0] STS_RESOLVED  = 2'd2;
    localparam logic [1:0] STS_REMOTE    = 2'd3;

    // entry flag bits
    localparam int FL_CRIT   = 0;
    localparam int FL_READY  = 1;
    localparam int FL_IMPACT = 2;
    localparam int FL_REMOTE = 3;

    typedef struct packed {
        logic        valid;
        logic [31:0] handle;
        logic [31:0] key;
        logic [30:0] local_amt;
        logic [3:0]  line;
        logic [31:0] stamp;
        logic [30:0] reply;
        logic [3:0]  flags;
        logic [4:0]  follow;
    } t_entry;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] ts;
        logic [31:0] handle;
        logic [31:0] key;
        logic [3:0]  line;
        logic [31:0] amt;
        logic [30:0] rep;
        logic        crit;
        logic [4:0]  follow;
        logic        remote;
    } t_req;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  follow;
        logic        crit;
        logic [30:0] shown;
        logic        ready;
        logic [1:0]  status;
    } t_res;

endpackage

// File: design/pending_result_match_table_top.sv
// Pending result match table. A ring of ENTRIES slots in one single-port-read,
// single-port-write memory pairs locally predicted damage with the server's
// reply. One word is taken at a time: s_axis_tready is high only while the
// sequencer is idle, and the result word sits in an output register, so the
// next word is taken while the previous result still waits on m_axis.
// Record, begin, end (depth stays above zero) and unknown codes go straight
// to the result state; so does a rejected reply or impact. A reply
// or impact walks the memory from the oldest slot, one slot per cycle through
// the single read port, and stops at the first match. An end that brings
// the depth to zero walks every slot to drop remote entries, and clear-all
// writes every slot once. After reset a clearing pass over every slot runs
// before the first word is taken; the timeout register may be written during
// it. Timeout writes are taken at any time and should be made while idle.
module pending_result_match_table_top #(
    parameter int ENTRIES = prmt_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // operation [2:0], remote_flag [3]
    input  logic [prmt_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // timestamp_ms [31:0], target_handle [63:32], object_key [95:64],
    // line_number [99:96], amount [131:100], reply_amount [162:132],
    // crit_flag [163], follow_line [168:164], zero pad [175:169]
    input  logic [prmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // status [1:0], ready_to_render [2], shown_amount [33:3],
    // shown_crit [34], shown_follow_line [39:35]
    output logic [prmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // timeout_ms write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prmt_pkg::CFG_W-1:0]      i_cfg_data
);
    import prmt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    // control
    t_state             r_state, n_state;
    logic               r_boot, n_boot;       // clearing pass after reset
    logic [IDX_W-1:0]   r_addr, n_addr;       // walk address
    logic [CNT_W-1:0]   r_cnt, n_cnt;         // slots issued in this walk
    logic               r_rd_vld, n_rd_vld;   // r_rd_data holds a walked slot
    logic [IDX_W-1:0]   r_slot, n_slot;       // next write slot (= oldest)
    logic [7:0]         r_depth, n_depth;     // nesting depth
    logic [CFG_W-1:0]   r_timeout;
    logic               r_out_valid;

    // payload
    t_req               r_req, n_req;
    t_res               r_res, n_res;
    t_res               r_out;
    logic [IDX_W-1:0]   r_eval_addr;

    // table memory
    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    t_req               in_req;
    t_entry             rec_word;
    logic               accept;
    logic               out_load;
    logic               issue;
    logic [31:0]        age;
    logic               expired;
    logic               live;
    logic               rep_hit;
    logic               imp_hit;
    logic [IDX_W-1:0]   addr_inc;
    logic [IDX_W-1:0]   slot_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign out_load      = (r_state == S_RESULT) && (!r_out_valid || m_axis_tready);

    // unpack the input word
    always_comb begin
        in_req.op     = s_axis_tuser[2:0];
        in_req.remote = s_axis_tuser[3];
        in_req.ts     = s_axis_tdata[31:0];
        in_req.handle = s_axis_tdata[63:32];
        in_req.key    = s_axis_tdata[95:64];
        in_req.line   = s_axis_tdata[99:96];
        in_req.amt    = s_axis_tdata[131:100];
        in_req.rep    = s_axis_tdata[162:132];
        in_req.crit   = s_axis_tdata[163];
        in_req.follow = s_axis_tdata[168:164];
    end

    // entry written by a record; a remote record already carries its reply
    always_comb begin
        rec_word           = '0;
        rec_word.valid     = (in_req.handle != 32'd0);
        rec_word.handle    = in_req.handle;
        rec_word.key       = in_req.key;
        rec_word.local_amt = in_req.amt[30:0];
        rec_word.line      = in_req.line;
        rec_word.stamp     = in_req.ts;
        if (in_req.remote) begin
            rec_word.reply             = in_req.rep;
            rec_word.flags[FL_CRIT]    = in_req.crit;
            rec_word.flags[FL_READY]   = 1'b1;
            rec_word.flags[FL_REMOTE]  = 1'b1;
            rec_word.follow            = in_req.follow;
        end
    end

    // ring wrap
    assign addr_inc = (r_addr == IDX_W'(ENTRIES - 1)) ? '0 : r_addr + 1'b1;
    assign slot_inc = (r_slot == IDX_W'(ENTRIES - 1)) ? '0 : r_slot + 1'b1;

    // compare of the walked slot: modular age, then the match terms
    assign age     = r_req.ts - r_rd_data.stamp;
    assign expired = (age > {16'd0, r_timeout});
    assign live    = r_rd_data.valid && !expired;
    assign rep_hit = live && !r_rd_data.flags[FL_REMOTE] && !r_rd_data.flags[FL_READY]
                     && (r_rd_data.key == r_req.key) && (r_rd_data.line == r_req.line);
    assign imp_hit = live && (r_rd_data.handle == r_req.handle)
                     && ({1'b0, r_rd_data.local_amt} == r_req.amt)
                     && (r_rd_data.line == r_req.line) && !r_rd_data.flags[FL_IMPACT]
                     && (r_rd_data.flags[FL_REMOTE] == (r_depth != 8'd0));

    assign issue = (r_cnt != CNT_W'(ENTRIES));

    // sequencer
    always_comb begin
        t_entry upd;
        n_state  = r_state;
        n_boot   = r_boot;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_rd_vld = 1'b0;
        n_slot   = r_slot;
        n_depth  = r_depth;
        n_req    = r_req;
        n_res    = r_res;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_eval_addr;
        upd      = r_rd_data;
        wr_data  = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req        = in_req;
                    n_res        = '0;
                    n_res.status = STS_UNCHANGED;
                    n_addr       = r_slot;
                    n_cnt        = '0;
                    n_state      = S_RESULT;
                    unique case (in_req.op)
                        OP_RECORD: begin
                            wr_en   = 1'b1;
                            wr_addr = r_slot;
                            wr_data = rec_word;
                            n_slot  = slot_inc;
                        end
                        OP_REPLY: begin
                            if (in_req.key != 32'd0 && !in_req.amt[31]) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_IMPACT: begin
                            if (in_req.handle != 32'd0 && !in_req.amt[31]) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_BEGIN: begin
                            if (r_depth != DEPTH_MAX) begin
                                n_depth = r_depth + 8'd1;
                            end
                        end
                        OP_END: begin
                            if (r_depth != 8'd0) begin
                                n_depth = r_depth - 8'd1;
                                // depth back to zero: drop remote entries
                                if (r_depth == 8'd1) begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_slot  = '0;
                            n_addr  = '0;
                            n_state = S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                if (issue) begin
                    rd_en    = 1'b1;
                    n_addr   = addr_inc;
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    case (r_req.op)
                        OP_REPLY: begin
                            if (rep_hit) begin
                                wr_en = 1'b1;
                                if (r_rd_data.flags[FL_IMPACT]) begin
                                    upd.valid   = 1'b0;
                                    n_res.ready = 1'b1;
                                end else begin
                                    upd.reply            = r_req.amt[30:0];
                                    upd.flags[FL_CRIT]   = r_req.crit;
                                    upd.flags[FL_READY]  = 1'b1;
                                    upd.follow           = r_req.follow;
                                end
                                n_rd_vld = 1'b0;
                                n_state  = S_RESULT;
                            end else if (r_rd_data.valid && expired) begin
                                wr_en     = 1'b1;
                                upd.valid = 1'b0;
                            end
                        end
                        OP_IMPACT: begin
                            if (imp_hit) begin
                                wr_en = 1'b1;
                                if (r_rd_data.flags[FL_READY]) begin
                                    upd.valid    = 1'b0;
                                    n_res.shown  = r_rd_data.reply;
                                    n_res.crit   = r_rd_data.flags[FL_CRIT];
                                    n_res.follow = r_rd_data.follow;
                                    n_res.status = r_rd_data.flags[FL_REMOTE] ?
                                                   STS_REMOTE : STS_RESOLVED;
                                end else begin
                                    upd.flags[FL_IMPACT] = 1'b1;
                                    n_res.status         = STS_WAIT;
                                end
                                n_rd_vld = 1'b0;
                                n_state  = S_RESULT;
                            end else if (r_rd_data.valid && expired) begin
                                wr_en     = 1'b1;
                                upd.valid = 1'b0;
                            end
                        end
                        OP_END: begin
                            if (r_rd_data.valid && r_rd_data.flags[FL_REMOTE]) begin
                                wr_en     = 1'b1;
                                upd.valid = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    wr_data = upd;
                end else if (!issue) begin
                    n_state = S_RESULT;
                end
            end

            S_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
                n_addr  = addr_inc;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ENTRIES - 1)) begin
                    n_state = r_boot ? S_IDLE : S_RESULT;
                    n_boot  = 1'b0;
                end
            end

            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_boot      <= 1'b1;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_slot      <= '0;
            r_depth     <= 8'd0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_boot      <= n_boot;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_slot      <= n_slot;
            r_depth     <= n_depth;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            r_out_valid <= out_load || (r_out_valid && !m_axis_tready);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        if (rd_en) begin
            r_eval_addr <= r_addr;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    // the walk never issues more reads than there are slots
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ENTRIES))
        else $error("walk count past table size");

    // read data is only evaluated during a walk
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> r_state == S_SCAN)
        else $error("read pending outside walk");

    // begin below the ceiling raises the depth by one
    a_depth_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (in_req.op == OP_BEGIN) && (r_depth != DEPTH_MAX)
        |=> r_depth == 8'($past(r_depth) + 8'd1))
        else $error("nest depth not raised");

endmodule
